[sv/pltl_pkg.sv]
// Package with shared types and constants for the peer liveness tracker.
package pltl_pkg;

  localparam int MaxPeers = 12;
  localparam int SlotW = 4;
  localparam int AliveW = 5;

  localparam logic [15:0] TimeoutReset = 16'd2000;
  localparam logic [15:0] DupWindowReset = 16'd1000;

  localparam logic [0:0] CfgTimeout = 1'b0;
  localparam logic [0:0] CfgDupWindow = 1'b1;

  localparam logic ActPacket = 1'b0;
  localparam logic ActScan = 1'b1;

  localparam logic [2:0] EvAccepted = 3'd0;
  localparam logic [2:0] EvDuplicate = 3'd1;
  localparam logic [2:0] EvFull = 3'd2;
  localparam logic [2:0] EvLost = 3'd3;
  localparam logic [2:0] EvScanDone = 3'd4;

  localparam logic [1:0] ContactNone = 2'd0;
  localparam logic [1:0] ContactFound = 2'd1;
  localparam logic [1:0] ContactRejoin = 2'd2;

  typedef struct packed {
    logic        action;
    logic [7:0]  peer_id;
    logic [15:0] seq_num;
    logic [31:0] sender_time_ms;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [1:0]  contact;
    logic        reboot_seen;
    logic [3:0]  slot;
    logic [7:0]  peer_tag;
    logic [31:0] received_count;
    logic [31:0] expected_count;
    logic [31:0] duplicate_count;
    logic [4:0]  alive_total;
    logic        last;
  } result_t;

  // Per-slot record held in the table.
  typedef struct packed {
    logic [7:0]  peer;
    logic [31:0] rx;
    logic [31:0] ex;
    logic [31:0] dup;
    logic [15:0] seq;
    logic [31:0] stime;
    logic [31:0] heard;
  } entry_t;

endpackage

[sv/pltl_table.sv]
// Slot table: used and alive flags in flip-flops, records in a register array.
module pltl_table (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [pltl_pkg::SlotW-1:0]       rd_slot,
  output pltl_pkg::entry_t                 rd_entry,
  output logic                             rd_used,
  output logic                             rd_alive,
  input  logic                             wr_en,
  input  logic [pltl_pkg::SlotW-1:0]       wr_slot,
  input  pltl_pkg::entry_t                 wr_entry,
  input  logic                             wr_alive,
  output logic [pltl_pkg::AliveW-1:0]      alive_count
);

  pltl_pkg::entry_t entries [pltl_pkg::MaxPeers];
  logic [pltl_pkg::MaxPeers-1:0] used;
  logic [pltl_pkg::MaxPeers-1:0] alive;
  logic [pltl_pkg::SlotW-1:0] rd_idx;

  // Slot indices beyond the table read as an unused slot.
  assign rd_idx = (32'(rd_slot) < pltl_pkg::MaxPeers) ? rd_slot : '0;
  assign rd_entry = entries[rd_idx];
  assign rd_used = (32'(rd_slot) < pltl_pkg::MaxPeers) && used[rd_idx];
  assign rd_alive = rd_used && alive[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      alive <= '0;
    end else if (wr_en) begin
      used[wr_slot] <= 1'b1;
      alive[wr_slot] <= wr_alive;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_slot] <= wr_entry;
    end
  end

  always_comb begin
    alive_count = '0;
    for (int i = 0; i < pltl_pkg::MaxPeers; i++) begin
      alive_count = alive_count + pltl_pkg::AliveW'(used[i] & alive[i]);
    end
  end

endmodule

[sv/peer_table_loss_liveness_tracker_top.sv]
// Top level of the peer liveness tracker: sequencer walking the slot table.
// A packet keeps busy high while it searches the slots for the id match (up to 12),
// then the slots for a free one (up to 12 more), and through one update step; a
// packet that finds the table full ends after the free search with no update. A
// scan keeps busy high while it walks every slot and through one closing step that
// reports the alive count. Every result is registered and appears in the cycle
// after the step that produced it, so the final result of an item is on the ports
// in the first cycle after busy falls. The slot walk goes through one table read port.
// Results appear for exactly one cycle with strobe high and cannot be stalled by
// the receiver.
module peer_table_loss_liveness_tracker_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  pltl_pkg::item_t     item,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output logic                strobe,
  output pltl_pkg::result_t   result
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_FIND   = 6'b000010,
    S_FREE   = 6'b000100,
    S_UPDATE = 6'b001000,
    S_SCAN   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state;
  pltl_pkg::item_t cur;
  logic [pltl_pkg::SlotW-1:0] idx;
  logic new_slot;
  logic [15:0] timeout_ms;
  logic [15:0] dup_window;

  pltl_pkg::entry_t rd_entry, wr_entry, upd;
  logic rd_used, rd_alive, wr_en, wr_alive;
  logic [pltl_pkg::SlotW-1:0] wr_slot;
  logic [pltl_pkg::AliveW-1:0] alive_count;
  logic last_slot;
  logic strobe_next;
  pltl_pkg::result_t result_next;

  pltl_table u_table (
    .clk(clk), .rst(rst),
    .rd_slot(idx), .rd_entry(rd_entry), .rd_used(rd_used), .rd_alive(rd_alive),
    .wr_en(wr_en), .wr_slot(wr_slot), .wr_entry(wr_entry), .wr_alive(wr_alive),
    .alive_count(alive_count)
  );

  assign busy = (state != S_IDLE);
  assign last_slot = (32'(idx) == pltl_pkg::MaxPeers - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= pltl_pkg::TimeoutReset;
      dup_window <= pltl_pkg::DupWindowReset;
    end else if (cfg_we) begin
      case (cfg_index)
        pltl_pkg::CfgTimeout:   timeout_ms <= cfg_data;
        pltl_pkg::CfgDupWindow: dup_window <= cfg_data;
        default: ;
      endcase
    end
  end

  // Packet update datapath working on the selected slot.
  logic [31:0] rx0, ex0, dup0;
  logic [15:0] delta;
  logic reboot, is_dup;
  pltl_pkg::entry_t base;

  always_comb begin
    base = rd_entry;
    if (new_slot) begin
      base = '0;
      base.peer = cur.peer_id;
    end
    reboot = (base.rx != 32'd0) && (cur.sender_time_ms < base.stime);
    rx0 = reboot ? 32'd0 : base.rx;
    ex0 = reboot ? 32'd0 : base.ex;
    dup0 = reboot ? 32'd0 : base.dup;
    delta = cur.seq_num - base.seq;
    is_dup = 1'b0;
    upd = base;
    upd.stime = cur.sender_time_ms;
    upd.heard = cur.now_ms;
    upd.dup = dup0;
    if (rx0 == 32'd0) begin
      upd.rx = 32'd1;
      upd.ex = 32'd1;
      upd.seq = cur.seq_num;
    end else if (delta == 16'd0 || delta > dup_window) begin
      is_dup = 1'b1;
      upd.rx = rx0;
      upd.ex = ex0;
      upd.dup = dup0 + 32'd1;
    end else begin
      upd.rx = rx0 + 32'd1;
      upd.ex = ex0 + 32'(delta);
      upd.seq = cur.seq_num;
    end
  end

  logic lost;
  assign lost = rd_alive && ((cur.now_ms - rd_entry.heard) > 32'(timeout_ms));

  always_comb begin
    wr_en = 1'b0;
    wr_slot = idx;
    wr_entry = upd;
    wr_alive = 1'b1;
    if (state == S_UPDATE) begin
      wr_en = 1'b1;
    end else if (state == S_SCAN && lost) begin
      wr_en = 1'b1;
      wr_entry = rd_entry;
      wr_alive = 1'b0;
    end
  end

  // The lost result reports the alive count after this slot is cleared.
  always_comb begin
    strobe_next = 1'b0;
    result_next = '0;
    case (state)
      S_FREE: begin
        if (rd_used && last_slot) begin
          strobe_next = 1'b1;
          result_next.event_res = pltl_pkg::EvFull;
          result_next.peer_tag = cur.peer_id;
          result_next.alive_total = alive_count;
          result_next.last = 1'b1;
        end
      end
      S_UPDATE: begin
        strobe_next = 1'b1;
        result_next.event_res = is_dup ? pltl_pkg::EvDuplicate : pltl_pkg::EvAccepted;
        if (!rd_alive || new_slot) begin
          result_next.contact = (upd.rx <= 32'd1) ? pltl_pkg::ContactFound
                                                  : pltl_pkg::ContactRejoin;
        end else begin
          result_next.contact = pltl_pkg::ContactNone;
        end
        result_next.reboot_seen = reboot;
        result_next.slot = idx;
        result_next.peer_tag = upd.peer;
        result_next.received_count = upd.rx;
        result_next.expected_count = upd.ex;
        result_next.duplicate_count = upd.dup;
        result_next.alive_total = alive_count
                                + pltl_pkg::AliveW'(!rd_alive || new_slot);
        result_next.last = 1'b1;
      end
      S_SCAN: begin
        if (lost) begin
          strobe_next = 1'b1;
          result_next.event_res = pltl_pkg::EvLost;
          result_next.slot = idx;
          result_next.peer_tag = rd_entry.peer;
          result_next.received_count = rd_entry.rx;
          result_next.expected_count = rd_entry.ex;
          result_next.duplicate_count = rd_entry.dup;
          result_next.alive_total = alive_count - 1'b1;
        end
      end
      S_DONE: begin
        strobe_next = 1'b1;
        result_next.event_res = pltl_pkg::EvScanDone;
        result_next.alive_total = alive_count;
        result_next.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      strobe <= 1'b0;
      idx <= '0;
      new_slot <= 1'b0;
    end else begin
      strobe <= strobe_next;
      result <= result_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            cur <= item;
            idx <= '0;
            new_slot <= 1'b0;
            state <= (item.action == pltl_pkg::ActScan) ? S_SCAN : S_FIND;
          end
        end
        S_FIND: begin
          if (rd_used && rd_entry.peer == cur.peer_id) begin
            state <= S_UPDATE;
          end else if (last_slot) begin
            idx <= '0;
            state <= S_FREE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_FREE: begin
          if (!rd_used) begin
            new_slot <= 1'b1;
            state <= S_UPDATE;
          end else if (last_slot) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_UPDATE: begin
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (last_slot) begin
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
